### rtl/djs_pkg.sv
// shared types, widths and constants for the deadline job penalty scheduler
// no dependencies
package djs_pkg;

	localparam int MAX_JOBS_DEF = 1024;
	localparam int DL_W = 16;
	localparam int PEN_W = 16;
	localparam int TOT_W = 26;
	localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

	typedef struct packed {
		logic [DL_W-1:0] deadline;
		logic [PEN_W-1:0] penalty;
		logic last_job;
	} in_t;

	typedef struct packed {
		logic [TOT_W-1:0] total_penalty;
		logic overflow;
	} out_t;

	typedef struct packed {
		logic [DL_W-1:0] deadline;
		logic [PEN_W-1:0] penalty;
	} job_t;

	// sort chain control
	typedef struct packed {
		logic load;
		logic shift;
	} sort_ctrl_t;

	// kept-penalty chain control
	typedef struct packed {
		logic ins;
		logic rep;
		logic clr;
	} keep_ctrl_t;

	// true if job a must stand before job b
	function automatic logic goes_before(job_t a, job_t b);
		if (a.deadline == b.deadline)
			return a.penalty > b.penalty;
		return a.deadline < b.deadline;
	endfunction

endpackage

### rtl/djs_sort_cell.sv
// one cell of the insertion-sorting job chain
// depends on djs_pkg
module djs_sort_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  djs_pkg::sort_ctrl_t ctrl,
	input  djs_pkg::job_t      new_job,
	input  logic               prev_ins,
	input  djs_pkg::job_t      prev_job,
	input  logic               prev_vld,
	input  djs_pkg::job_t      next_job,
	input  logic               next_vld,
	output djs_pkg::job_t      job,
	output logic               vld,
	output logic               ins
);
	djs_pkg::job_t job_q;
	logic vld_q;

	// new job belongs here or earlier
	assign ins = !vld_q || djs_pkg::goes_before(new_job, job_q);

	// valid bit: a shifted-in entry carries its neighbor's valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.shift) begin
			vld_q <= next_vld;
		end else if (ctrl.load && ins) begin
			vld_q <= prev_ins ? prev_vld : 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			job_q <= next_job;
		end else if (ctrl.load && ins) begin
			job_q <= prev_ins ? prev_job : new_job;
		end
	end

	assign job = job_q;
	assign vld = vld_q;
endmodule

### rtl/djs_keep_cell.sv
// one cell of the ascending chain of kept penalties, minimum at the head
// depends on djs_pkg
module djs_keep_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  djs_pkg::keep_ctrl_t     ctrl,
	input  logic [djs_pkg::PEN_W-1:0] x,
	input  logic                    first,
	input  logic                    prev_lt,
	input  logic [djs_pkg::PEN_W-1:0] prev_val,
	input  logic                    prev_vld,
	input  logic                    next_lt,
	input  logic [djs_pkg::PEN_W-1:0] next_val,
	output logic                    lt,
	output logic [djs_pkg::PEN_W-1:0] val,
	output logic                    vld
);
	logic [djs_pkg::PEN_W-1:0] val_q;
	logic vld_q;

	assign lt = vld_q && (val_q < x);

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.clr) begin
			vld_q <= 1'b0;
		end else if (ctrl.ins && !lt) begin
			vld_q <= (first || prev_lt) ? 1'b1 : prev_vld;
		end else if (ctrl.rep && (next_lt || first || lt)) begin
			vld_q <= 1'b1;
		end
	end

	// payload: insert shifts larger values up, replace drops the head
	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt) begin
			val_q <= (first || prev_lt) ? x : prev_val;
		end else if (ctrl.rep) begin
			if (next_lt) begin
				val_q <= next_val;
			end else if (first || lt) begin
				val_q <= x;
			end
		end
	end

	assign val = val_q;
	assign vld = vld_q;
endmodule

### rtl/deadline_job_penalty_scheduler.sv
// top level: sort chain, kept-penalty chain, greedy pass control, output register
// depends on djs_pkg, djs_sort_cell, djs_keep_cell
//
// channel | dir | handshake          | word
// in      | in  | in_valid/in_ready   | djs_pkg::in_t
// out     | out | out_valid/out_ready | djs_pkg::out_t
//
// jobs load one per cycle while in_ready is high; each is placed in order by the
// sort chain at once; after the last job the pass takes one stored job per cycle
// from the head of the sort chain, then hands the result to the output register
// in_ready is low during the pass, and longer while an older result waits
// the result waits in an output register; a new set loads while it waits
// reset clears all valid bits and counters; no clearing pass is needed
module deadline_job_penalty_scheduler #(
	parameter int MAX_JOBS = djs_pkg::MAX_JOBS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  djs_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output djs_pkg::out_t out_data
);
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int XW = djs_pkg::DL_W + 1;
	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_PASS = 1'b1;

	logic state_q;
	logic [CW-1:0] count_q, rem_q, kept_q;
	logic ovf_q, ovf_pass_q;
	logic [djs_pkg::TOT_W-1:0] total_q;
	logic out_valid_q;
	djs_pkg::out_t out_q;

	djs_pkg::sort_ctrl_t sctrl;
	djs_pkg::keep_ctrl_t kctrl;
	djs_pkg::job_t new_job;
	djs_pkg::job_t sjob [MAX_JOBS];
	logic svld [MAX_JOBS];
	logic sins [MAX_JOBS];
	logic [djs_pkg::PEN_W-1:0] kval [MAX_JOBS];
	logic klt [MAX_JOBS];
	logic kvld [MAX_JOBS];

	logic acc, store, step, keep, rep, finish;
	logic [djs_pkg::PEN_W-1:0] drop_pen;
	logic [djs_pkg::TOT_W:0] sum;

	assign in_ready = (state_q == ST_LOAD);
	assign acc = in_valid && in_ready;
	assign store = acc && (count_q != CW'(MAX_JOBS));
	assign step = (state_q == ST_PASS) && (rem_q != '0);
	assign finish = (state_q == ST_PASS) && (rem_q == '0) && (!out_valid_q || out_ready);

	// greedy decision on the head job
	assign keep = {1'b0, sjob[0].deadline} > XW'(kept_q);
	assign rep = !keep && kvld[0] && (kval[0] < sjob[0].penalty);
	assign drop_pen = rep ? kval[0] : sjob[0].penalty;
	assign sum = {1'b0, total_q} + (djs_pkg::TOT_W+1)'(drop_pen);

	assign new_job.deadline = in_data.deadline;
	assign new_job.penalty = in_data.penalty;
	assign sctrl.load = store;
	assign sctrl.shift = step;
	assign kctrl.ins = step && keep;
	assign kctrl.rep = step && rep;
	assign kctrl.clr = acc && in_data.last_job;

	// cell chains
	genvar i;
	generate
		for (i = 0; i < MAX_JOBS; i++) begin : g_cell
			djs_sort_cell u_sort (
				.clk(clk), .arst_n(arst_n), .ctrl(sctrl), .new_job(new_job),
				.prev_ins((i == 0) ? 1'b0 : sins[(i == 0) ? 0 : i-1]),
				.prev_job(sjob[(i == 0) ? 0 : i-1]),
				.prev_vld((i == 0) ? 1'b0 : svld[(i == 0) ? 0 : i-1]),
				.next_job(sjob[(i == MAX_JOBS-1) ? i : i+1]),
				.next_vld((i == MAX_JOBS-1) ? 1'b0 : svld[(i == MAX_JOBS-1) ? i : i+1]),
				.job(sjob[i]), .vld(svld[i]), .ins(sins[i])
			);
			djs_keep_cell u_keep (
				.clk(clk), .arst_n(arst_n), .ctrl(kctrl), .x(sjob[0].penalty),
				.first(i == 0),
				.prev_lt((i == 0) ? 1'b0 : klt[(i == 0) ? 0 : i-1]),
				.prev_val(kval[(i == 0) ? 0 : i-1]),
				.prev_vld((i == 0) ? 1'b0 : kvld[(i == 0) ? 0 : i-1]),
				.next_lt((i == MAX_JOBS-1) ? 1'b0 : klt[(i == MAX_JOBS-1) ? i : i+1]),
				.next_val(kval[(i == MAX_JOBS-1) ? i : i+1]),
				.lt(klt[i]), .val(kval[i]), .vld(kvld[i])
			);
		end
	endgenerate

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			rem_q <= '0;
			kept_q <= '0;
			ovf_q <= 1'b0;
			ovf_pass_q <= 1'b0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (acc) begin
						if (in_data.last_job) begin
							state_q <= ST_PASS;
							rem_q <= store ? count_q + CW'(1) : count_q;
							ovf_pass_q <= ovf_q || !store;
							kept_q <= '0;
							total_q <= '0;
							count_q <= '0;
							ovf_q <= 1'b0;
						end else if (store) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_PASS: begin
					if (step) begin
						rem_q <= rem_q - CW'(1);
						if (keep)
							kept_q <= kept_q + CW'(1);
						else
							total_q <= sum[djs_pkg::TOT_W] ? djs_pkg::TOT_MAX
								: sum[djs_pkg::TOT_W-1:0];
					end else if (finish) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.total_penalty <= total_q;
			out_q.overflow <= ovf_pass_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule

### rtl/djs_checker.sv
// port-level checks for the deadline job penalty scheduler, bound to the top level
// depends on djs_pkg and deadline_job_penalty_scheduler
module djs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input djs_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input djs_pkg::out_t out_data
);
	// a waiting result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// the pass starts right after the last job of a set
	a_pass_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_job |=> !in_ready)
		else $error("input still taken after last job");

	// a result appears only at the end of a pass
	a_out_after_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a pass");

	// the pass ends with the input open again
	a_pass_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("input closed after result");
endmodule

bind deadline_job_penalty_scheduler djs_checker u_djs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
	.out_data(out_data)
);
